FILE: sv/kmshr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmshr_pkg
// Shared constants and helpers for the keypad matrix scanner.
// ----------------------------------------------------------------------------
package kmshr_pkg;

  localparam int unsigned NUM_KEYS     = 18;
  localparam int unsigned NUM_ROWS     = 4;
  localparam int unsigned MAX_COLS     = 5;
  localparam int unsigned REPORT_SLOTS = 6;

  localparam int unsigned RowW      = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int unsigned ColInW    = 5;
  localparam int unsigned DriveW    = 4;
  localparam int unsigned CodeW     = 8;
  localparam int unsigned OutSlots  = 6;
  localparam int unsigned CntW      = 6;
  localparam int unsigned InDataW   = 8;
  localparam int unsigned OutDataW  = 56;

  typedef logic [NUM_KEYS-1:0] key_vec_t;
  typedef logic [RowW-1:0]     row_idx_t;
  typedef logic [CodeW-1:0]    code_t;

  function automatic int unsigned row_cols(input int unsigned r);
    if (r < 2) begin
      return MAX_COLS;
    end
    return (MAX_COLS > 1) ? MAX_COLS - 1 : 0;
  endfunction

  function automatic int unsigned row_base(input int unsigned r);
    int unsigned b;
    b = 0;
    for (int unsigned k = 0; k < r; k++) begin
      b += row_cols(k);
    end
    return b;
  endfunction

  function automatic logic [DriveW-1:0] drive_for(input row_idx_t r);
    logic [DriveW-1:0] d;
    d = '1;
    for (int unsigned i = 0; i < DriveW; i++) begin
      if (32'(r) == i) begin
        d[i] = 1'b0;
      end
    end
    return d;
  endfunction

  function automatic code_t usage_code(input int unsigned k);
    code_t c;
    case (k)
      0:       c = 8'h53;
      1:       c = 8'h5F;
      2:       c = 8'h60;
      3:       c = 8'h61;
      4:       c = 8'h57;
      5:       c = 8'h56;
      6:       c = 8'h5C;
      7:       c = 8'h5D;
      8:       c = 8'h5E;
      9:       c = 8'h2A;
      10:      c = 8'h38;
      11:      c = 8'h59;
      12:      c = 8'h5A;
      13:      c = 8'h5B;
      14:      c = 8'h55;
      15:      c = 8'h62;
      16:      c = 8'h37;
      17:      c = 8'h58;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

FILE: sv/keypad_matrix_scan_hid_report_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_matrix_scan_hid_report_top
// Row-by-row keypad matrix scanner producing HID keyboard key reports.
// ----------------------------------------------------------------------------
// Output: an accepted row sample's result is registered into the output
//   register.
// Throughput: one row sample per cycle unless m_axis_tready back-pressure
//   stalls it; the output register is the only stage, refilled in the cycle it is taken.
// Reset: row 0, all keys released, no report sent yet, output empty.
module keypad_matrix_scan_hid_report_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [4:0] col_levels
  input  logic [kmshr_pkg::InDataW-1:0]     s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [3:0] row_drive, [11:4] key_slot_0 ... [51:44] key_slot_5
  output logic [kmshr_pkg::OutDataW-1:0]    m_axis_tdata,
  // [0] report_valid
  output logic                              m_axis_tuser
);

  localparam int unsigned NK = kmshr_pkg::NUM_KEYS;

  kmshr_pkg::row_idx_t row_q, row_d;
  kmshr_pkg::key_vec_t keys_q, keys_d;
  kmshr_pkg::key_vec_t rep_keys_q, rep_keys_d;
  logic                rep_once_q, rep_once_d;
  logic                out_valid_q;
  logic [kmshr_pkg::DriveW-1:0] drive_q, drive_d;
  logic                rep_q, rep_d;
  kmshr_pkg::code_t    slot_q [kmshr_pkg::OutSlots];
  kmshr_pkg::code_t    slot_d [kmshr_pkg::OutSlots];
  logic [kmshr_pkg::CntW-1:0] below_cnt [NK];

  logic [kmshr_pkg::ColInW-1:0] cols;
  logic                         accept;
  logic                         last_row;

  assign cols          = s_axis_tdata[kmshr_pkg::ColInW-1:0];
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign last_row      = (row_q == kmshr_pkg::row_idx_t'(kmshr_pkg::NUM_ROWS - 1));

  // key vector update from the current row sample
  always_comb begin
    keys_d = keys_q;
    for (int unsigned r = 0; r < kmshr_pkg::NUM_ROWS; r++) begin
      for (int unsigned c = 0; c < kmshr_pkg::ColInW; c++) begin
        if (row_q == kmshr_pkg::row_idx_t'(r) && c < kmshr_pkg::row_cols(r) &&
            kmshr_pkg::row_base(r) + c < NK) begin
          keys_d[kmshr_pkg::row_base(r) + c] = cols[c];
        end
      end
    end
  end

  always_comb begin
    row_d = last_row ? '0 : row_q + kmshr_pkg::row_idx_t'(1);
    drive_d = kmshr_pkg::drive_for(row_d);
    rep_d = last_row && (!rep_once_q || keys_d != rep_keys_q);
    rep_once_d = rep_once_q || rep_d;
    rep_keys_d = rep_d ? keys_d : rep_keys_q;
  end

  // pressed keys below each position pick the slot
  always_comb begin
    for (int unsigned k = 0; k < NK; k++) begin
      below_cnt[k] = kmshr_pkg::CntW'($countones(~keys_d & ((NK)'(1) << k) - (NK)'(1)));
    end
  end

  always_comb begin
    for (int unsigned j = 0; j < kmshr_pkg::OutSlots; j++) begin
      slot_d[j] = '0;
      for (int unsigned k = 0; k < NK; k++) begin
        if (rep_d && j < kmshr_pkg::REPORT_SLOTS && !keys_d[k] &&
            below_cnt[k] == kmshr_pkg::CntW'(j)) begin
          slot_d[j] = slot_d[j] | kmshr_pkg::usage_code(k);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      keys_q      <= '1;
      rep_keys_q  <= '0;
      rep_once_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        row_q      <= row_d;
        keys_q     <= keys_d;
        rep_keys_q <= rep_keys_d;
        rep_once_q <= rep_once_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      drive_q <= drive_d;
      rep_q   <= rep_d;
      for (int unsigned j = 0; j < kmshr_pkg::OutSlots; j++) begin
        slot_q[j] <= slot_d[j];
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = rep_q;
  assign m_axis_tdata  = {4'h0, slot_q[5], slot_q[4], slot_q[3], slot_q[2],
                          slot_q[1], slot_q[0], drive_q};

  a_no_report_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[51:4] == '0))
    else $error("slots not cleared without report");

  a_drive_onehot_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($countones(~m_axis_tdata[3:0]) == 1 || m_axis_tdata[3:0] == 4'hF))
    else $error("row drive has more than one active row");

  a_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_row) |=> (row_q == '0))
    else $error("row index did not wrap after last row");

  a_report_sets_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && rep_d) |=> (rep_once_q && rep_keys_q == $past(keys_d)))
    else $error("report state not recorded");

  a_report_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !last_row) |=> !rep_q)
    else $error("report outside last row");

endmodule
